/* hdl/rmrpy_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to roll, pitch and yaw: shared package
// Widths, CORDIC angle table and fixed-point constants used across the design.
// ----------------------------------------------------------------------------
package rmrpy_pkg;

	localparam int DATA_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CFG_WIDTH         = 16;
	localparam int ROLL_WIDTH        = 16;
	localparam int PITCH_WIDTH       = 15;
	localparam int YAW_WIDTH         = 16;
	localparam int ZW                = 34;
	localparam int CW                = 60;

	localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
	localparam logic signed [ZW-1:0] ROUND_Q  = 34'sd65536;
	localparam int                   OUT_PI   = 25736;
	localparam int                   OUT_HPI  = 12868;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] t;
		unique case (i)
			0:  t = 34'sd843314857;
			1:  t = 34'sd497837829;
			2:  t = 34'sd263043837;
			3:  t = 34'sd133525159;
			4:  t = 34'sd67021687;
			5:  t = 34'sd33543516;
			6:  t = 34'sd16775851;
			7:  t = 34'sd8388437;
			8:  t = 34'sd4194283;
			9:  t = 34'sd2097149;
			default: t = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
		endcase
		return t;
	endfunction

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cordic_t;

endpackage

/* hdl/rmrpy_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries valid, ready and a payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface rmrpy_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/rmrpy_cordic_cell.sv */
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation with a fixed shift, registered when the chain advances.
// ----------------------------------------------------------------------------
module rmrpy_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              en,
	input  rmrpy_pkg::cordic_t d,
	output rmrpy_pkg::cordic_t q
);
	rmrpy_pkg::cordic_t n;
	always_comb begin
		n = d;
		if (!d.y[rmrpy_pkg::CW-1]) begin
			n.x = d.x + (d.y >>> SHIFT);
			n.y = d.y - (d.x >>> SHIFT);
			n.z = d.z + rmrpy_pkg::atan_q30(SHIFT);
		end else begin
			n.x = d.x - (d.y >>> SHIFT);
			n.y = d.y + (d.x >>> SHIFT);
			n.z = d.z - rmrpy_pkg::atan_q30(SHIFT);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q <= n;
		end
	end
endmodule

/* hdl/rmrpy_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// Square root cell
// One bit of a restoring integer square root, registered when the chain moves.
// ----------------------------------------------------------------------------
module rmrpy_sqrt_cell #(
	parameter int NW  = 64,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n_d,
	input  logic [NW-1:0] r_d,
	output logic [NW-1:0] n_q,
	output logic [NW-1:0] r_q
);
	localparam logic [NW-1:0] B = NW'(1) << (2 * BIT);
	always_ff @(posedge clk) begin
		if (en) begin
			if (n_d >= r_d + B) begin
				n_q <= n_d - (r_d + B);
				r_q <= (r_d >> 1) + B;
			end else begin
				n_q <= n_d;
				r_q <= r_d >> 1;
			end
		end
	end
endmodule

/* hdl/rmrpy_atan2.sv */
// ----------------------------------------------------------------------------
// Pipelined atan2
// Quadrant fold followed by a chain of CORDIC cells, rounding and clamping.
// ----------------------------------------------------------------------------
module rmrpy_atan2 #(
	parameter int IW     = 18,
	parameter int GUARD  = 40,
	parameter int STAGES = 16,
	parameter int LIM    = 25736,
	parameter int OW     = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [IW-1:0] y,
	input  logic signed [IW-1:0] x,
	output logic signed [OW-1:0] ang
);
	localparam int CW = rmrpy_pkg::CW;
	rmrpy_pkg::cordic_t c [STAGES+1];
	logic signed [CW-1:0] xs, ys;
	logic signed [rmrpy_pkg::ZW-1:0] zr, qv;

	always_comb begin
		xs = CW'(x) <<< GUARD;
		ys = CW'(y) <<< GUARD;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c[0].zero <= (x == '0) && (y == '0);
			if (x[IW-1]) begin
				c[0].x <= -xs;
				c[0].y <= -ys;
				c[0].z <= y[IW-1] ? -rmrpy_pkg::PI_Q30 : rmrpy_pkg::PI_Q30;
			end else begin
				c[0].x <= xs;
				c[0].y <= ys;
				c[0].z <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		rmrpy_cordic_cell #(.SHIFT(i)) u_cell (
			.clk(clk), .en(en), .d(c[i]), .q(c[i+1])
		);
	end

	always_comb begin
		zr = (c[STAGES].z + rmrpy_pkg::ROUND_Q) >>> 17;
		if (c[STAGES].zero) qv = '0;
		else if (zr > LIM) qv = rmrpy_pkg::ZW'(LIM);
		else if (zr < -LIM) qv = -rmrpy_pkg::ZW'(LIM);
		else qv = zr;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ang <= OW'(qv);
		end
	end
endmodule

/* hdl/rotation_matrix_to_roll_pitch_yaw.sv */
// ----------------------------------------------------------------------------
// Rotation matrix to roll, pitch and yaw
// Z-Y-X Euler angles from seven rotation matrix entries, fully pipelined.
// ----------------------------------------------------------------------------
// Order of work: squaring and square root, then two CORDIC passes,
// plus one output stage.
// Throughput: one item per cycle; the whole pipe advances whenever the
// output register is empty or being taken, so stalls hold every stage.
// Reset clears only valid bits and sets thr_q, the lock threshold, to 1.
module rotation_matrix_to_roll_pitch_yaw #(
	parameter int DATA_WIDTH    = rmrpy_pkg::DATA_WIDTH_DEF,
	parameter int CORDIC_STAGES = rmrpy_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rmrpy_pkg::CFG_WIDTH-1:0] cfg_wdata,
	input  logic signed [DATA_WIDTH-1:0] rot_00,
	input  logic signed [DATA_WIDTH-1:0] rot_10,
	input  logic signed [DATA_WIDTH-1:0] rot_20,
	input  logic signed [DATA_WIDTH-1:0] rot_21,
	input  logic signed [DATA_WIDTH-1:0] rot_22,
	input  logic signed [DATA_WIDTH-1:0] rot_02,
	input  logic signed [DATA_WIDTH-1:0] rot_12,
	input  logic in_valid,
	output logic in_ready,
	output logic signed [rmrpy_pkg::ROLL_WIDTH-1:0]  roll_angle,
	output logic signed [rmrpy_pkg::PITCH_WIDTH-1:0] pitch_angle,
	output logic signed [rmrpy_pkg::YAW_WIDTH-1:0]   yaw_angle,
	output logic gimbal_locked,
	output logic out_valid,
	input  logic out_ready
);
	localparam int DW    = DATA_WIDTH;
	localparam int NW    = 2 * DW + 2;
	localparam int SQ    = DW + 1;
	localparam int GUARD = 56 - DW;
	localparam int AW    = DW + 1;
	localparam int CL    = CORDIC_STAGES + 2;
	localparam int L1    = SQ + 1;
	localparam int LAT   = L1 + 2 * CL + 1;

	logic [rmrpy_pkg::CFG_WIDTH-1:0] thr_q;
	logic [LAT-1:0] vld_q;
	logic en;

	// The chain moves unless a finished item sits unclaimed at the output.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rmrpy_pkg::CFG_WIDTH'(1);
			vld_q <= '0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: squares, lock test and capture of the other entries.
	typedef struct packed {
		logic signed [DW-1:0] r00, r10, r20, r02, r12, r21, r22;
		logic lock;
	} side_t;
	side_t sd [SQ+2*CL+1];
	logic [NW-1:0] n_c [SQ+1];
	logic [NW-1:0] r_c [SQ+1];
	logic [DW:0] a21, a22;
	logic [DW+1:0] asum;

	always_comb begin
		a21  = rot_21[DW-1] ? (DW+1)'(-(DW+1)'(rot_21)) : (DW+1)'(rot_21);
		a22  = rot_22[DW-1] ? (DW+1)'(-(DW+1)'(rot_22)) : (DW+1)'(rot_22);
		asum = (DW+2)'(a21) + (DW+2)'(a22);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_c[0] <= NW'(rot_00 * rot_00) + NW'(rot_10 * rot_10);
			r_c[0] <= '0;
			sd[0] <= '{rot_00, rot_10, rot_20, rot_02, rot_12, rot_21, rot_22,
				asum < (DW+2)'(thr_q)};
		end
	end

	// Square root: one cell per result bit, side data travels alongside.
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		rmrpy_sqrt_cell #(.NW(NW), .BIT(SQ - 1 - k)) u_sq (
			.clk(clk), .en(en), .n_d(n_c[k]), .r_d(r_c[k]),
			.n_q(n_c[k+1]), .r_q(r_c[k+1])
		);
	end
	for (genvar k = 0; k < SQ + 2 * CL; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) sd[k+1] <= sd[k];
		end
	end

	// Pitch: atan2(-r20, hypot), starting when the root is complete.
	logic signed [AW-1:0] p_y, p_x;
	logic signed [rmrpy_pkg::PITCH_WIDTH-1:0] pitch_s;
	assign p_y = -AW'(sd[SQ].r20);
	assign p_x = AW'(r_c[SQ]);
	rmrpy_atan2 #(.IW(AW), .GUARD(GUARD), .STAGES(CORDIC_STAGES),
		.LIM(rmrpy_pkg::OUT_HPI), .OW(rmrpy_pkg::PITCH_WIDTH)) u_pitch (
		.clk(clk), .en(en), .y(p_y), .x(p_x), .ang(pitch_s)
	);

	// Roll and yaw run in a second CORDIC pass once pitch's sign is known.
	side_t sb;
	logic signed [AW-1:0] ry, rx, yy, yx;
	logic pos;
	assign sb  = sd[SQ+CL];
	assign pos = !pitch_s[rmrpy_pkg::PITCH_WIDTH-1] && (pitch_s != '0);
	always_comb begin
		ry = AW'(sb.r21);
		rx = AW'(sb.r22);
		if (sb.lock) begin
			yy = pos ? AW'(sb.r12) : -AW'(sb.r12);
			yx = pos ? AW'(sb.r02) : -AW'(sb.r02);
		end else begin
			yy = AW'(sb.r10);
			yx = AW'(sb.r00);
		end
	end
	logic signed [rmrpy_pkg::ROLL_WIDTH-1:0] roll_c;
	logic signed [rmrpy_pkg::YAW_WIDTH-1:0]  yaw_c;
	rmrpy_atan2 #(.IW(AW), .GUARD(GUARD), .STAGES(CORDIC_STAGES),
		.LIM(rmrpy_pkg::OUT_PI), .OW(rmrpy_pkg::ROLL_WIDTH)) u_roll (
		.clk(clk), .en(en), .y(ry), .x(rx), .ang(roll_c)
	);
	rmrpy_atan2 #(.IW(AW), .GUARD(GUARD), .STAGES(CORDIC_STAGES),
		.LIM(rmrpy_pkg::OUT_PI), .OW(rmrpy_pkg::YAW_WIDTH)) u_yaw (
		.clk(clk), .en(en), .y(yy), .x(yx), .ang(yaw_c)
	);

	// Pitch is delayed by one CORDIC pass to line up with roll and yaw.
	logic signed [rmrpy_pkg::PITCH_WIDTH-1:0] pd [CL+1];
	assign pd[0] = pitch_s;
	for (genvar k = 0; k < CL; k++) begin : g_pd
		always_ff @(posedge clk) begin
			if (en) pd[k+1] <= pd[k];
		end
	end

	// Output register; the lock flag is taken from the side data that lines
	// up with the end of the second CORDIC pass.
	always_ff @(posedge clk) begin
		if (en) begin
			gimbal_locked <= sd[SQ+2*CL].lock;
			roll_angle    <= sd[SQ+2*CL].lock ? '0 : roll_c;
			yaw_angle     <= yaw_c;
			pitch_angle   <= pd[CL];
		end
	end
endmodule

/* hdl/rmrpy_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for range and stall behavior.
// ----------------------------------------------------------------------------
module rmrpy_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic gimbal_locked,
	input logic signed [15:0] roll_angle,
	input logic signed [14:0] pitch_angle
);
	a_roll_lock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gimbal_locked |-> roll_angle == 16'sd0) else $error("roll");
	a_pitch_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
		else $error("pitch");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(roll_angle))
		else $error("hold");
endmodule

bind rotation_matrix_to_roll_pitch_yaw rmrpy_checker u_chk (.*);

/* tb/tb_rotation_matrix_to_roll_pitch_yaw.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to roll, pitch and yaw: testbench
// Streams directed and random matrices (true rotations, near gimbal lock, raw
// bit patterns) under several lock thresholds, with random stalls on both
// channels, and checks every angle triple against a bit-true predictor.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_roll_pitch_yaw;

	localparam int  DW        = rmrpy_pkg::DATA_WIDTH_DEF;
	localparam int  LATENCY   = DW + 2 + 2 * (rmrpy_pkg::CORDIC_STAGES_DEF + 2) + 1;
	localparam int  N_RANDOM  = 1700;
	localparam int  MAX_CYCLES = 600000;

	// One input item: the seven matrix entries that the block uses.
	typedef struct packed {
		logic signed [DW-1:0] r00;
		logic signed [DW-1:0] r10;
		logic signed [DW-1:0] r20;
		logic signed [DW-1:0] r21;
		logic signed [DW-1:0] r22;
		logic signed [DW-1:0] r02;
		logic signed [DW-1:0] r12;
	} matrix_t;

	// One result item: the three angles and the lock flag.
	typedef struct packed {
		logic signed [rmrpy_pkg::ROLL_WIDTH-1:0]  roll;
		logic signed [rmrpy_pkg::PITCH_WIDTH-1:0] pitch;
		logic signed [rmrpy_pkg::YAW_WIDTH-1:0]   yaw;
		logic                                     locked;
	} angles_t;

	// The angle predictor and the queue of expected angle triples.
	class attitude_ledger;
		angles_t pending[$];
		logic [rmrpy_pkg::CFG_WIDTH-1:0] threshold;
		int errors;
		int checked;
		int lock_count;
		longint atan_tab[16];

		function new();
			atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
				33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
				262144, 131072, 65536, 32768};
			threshold = 1;
			errors = 0;
			checked = 0;
			lock_count = 0;
		endfunction

		function longint root_floor(longint n);
			longint r;
			longint b;
			r = 0;
			b = longint'(1) <<< 62;
			while (b > n) b = b >>> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		// CORDIC vectoring with 40 guard bits, rounded to Q3.13 and clamped.
		function longint vector_angle(longint yin, longint xin, longint lim);
			longint x;
			longint y;
			longint z;
			longint dx;
			longint dy;
			longint q;
			if (xin == 0 && yin == 0) return 0;
			x = xin <<< (56 - DW);
			y = yin <<< (56 - DW);
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < rmrpy_pkg::CORDIC_STAGES_DEF; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx;
					y -= dy;
					z += atan_tab[i];
				end else begin
					x -= dx;
					y += dy;
					z -= atan_tab[i];
				end
			end
			q = (z + 65536) >>> 17;
			if (q > lim) q = lim;
			if (q < -lim) q = -lim;
			return q;
		endfunction

		function void note_matrix(matrix_t m);
			longint h;
			longint p;
			longint a;
			angles_t e;
			h = root_floor(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
			p = vector_angle(-longint'(m.r20), h, rmrpy_pkg::OUT_HPI);
			a = (m.r21 < 0 ? -longint'(m.r21) : longint'(m.r21)) +
				(m.r22 < 0 ? -longint'(m.r22) : longint'(m.r22));
			e.pitch = p;
			e.locked = (a < longint'(threshold));
			if (e.locked) begin
				e.roll = 0;
				if (p > 0)
					e.yaw = vector_angle(m.r12, m.r02, rmrpy_pkg::OUT_PI);
				else
					e.yaw = vector_angle(-longint'(m.r12), -longint'(m.r02),
						rmrpy_pkg::OUT_PI);
				lock_count++;
			end else begin
				e.roll = vector_angle(m.r21, m.r22, rmrpy_pkg::OUT_PI);
				e.yaw = vector_angle(m.r10, m.r00, rmrpy_pkg::OUT_PI);
			end
			pending = {pending, e};
		endfunction

		task report(string what, int got, int want);
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_angles(angles_t g);
			angles_t e;
			if (pending.size() == 0) begin
				report("unexpected result, roll", g.roll, 0);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (g.roll !== e.roll) report("roll", g.roll, e.roll);
			if (g.pitch !== e.pitch) report("pitch", g.pitch, e.pitch);
			if (g.yaw !== e.yaw) report("yaw", g.yaw, e.yaw);
			if (g.locked !== e.locked) report("lock flag", g.locked, e.locked);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rmrpy_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;
	logic steady = 1'b0; // when set, neither side idles
	int cycles = 0;

	rmrpy_if #(.T(matrix_t)) mat_ch ();
	rmrpy_if #(.T(angles_t)) ang_ch ();

	attitude_ledger ledger = new();

	always #5 clk = ~clk;

	rotation_matrix_to_roll_pitch_yaw u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.rot_00       (mat_ch.data.r00),
		.rot_10       (mat_ch.data.r10),
		.rot_20       (mat_ch.data.r20),
		.rot_21       (mat_ch.data.r21),
		.rot_22       (mat_ch.data.r22),
		.rot_02       (mat_ch.data.r02),
		.rot_12       (mat_ch.data.r12),
		.in_valid     (mat_ch.valid),
		.in_ready     (mat_ch.ready),
		.roll_angle   (ang_ch.data.roll),
		.pitch_angle  (ang_ch.data.pitch),
		.yaw_angle    (ang_ch.data.yaw),
		.gimbal_locked(ang_ch.data.locked),
		.out_valid    (ang_ch.valid),
		.out_ready    (ang_ch.ready)
	);

	initial begin
		mat_ch.valid = 1'b0;
		mat_ch.data = '0;
		ang_ch.ready = 1'b0;
	end

	// Both handshakes are sampled at the clock edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (mat_ch.valid && mat_ch.ready) ledger.note_matrix(mat_ch.data);
			if (ang_ch.valid && ang_ch.ready) ledger.check_angles(ang_ch.data);
		end
	end

	// The result side stalls about a third of the time unless in a steady stretch.
	always @(posedge clk) begin
		if (arst_n) ang_ch.ready <= steady || ($urandom_range(99) >= 33);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one item and holds it until the block takes it. Random gaps
	// come first; valid stays high between back-to-back items.
	task send_matrix(matrix_t m);
		while (!steady && $urandom_range(99) < 33) begin
			mat_ch.valid <= 1'b0;
			@(posedge clk);
		end
		mat_ch.valid <= 1'b1;
		mat_ch.data <= m;
		do @(posedge clk); while (!mat_ch.ready);
	endtask

	// Threshold changes happen only with the pipe drained and quiet.
	task set_threshold(logic [rmrpy_pkg::CFG_WIDTH-1:0] value);
		mat_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.threshold = value;
	endtask

	function automatic logic signed [DW-1:0] to_q14(real v);
		return DW'($rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5)));
	endfunction

	// Builds R = Rz(yaw) Ry(pitch) Rx(roll) in Q2.14.
	function automatic matrix_t euler_matrix(real r, real p, real y);
		matrix_t m;
		real sr, cr, sp, cp, sy, cy;
		sr = $sin(r); cr = $cos(r);
		sp = $sin(p); cp = $cos(p);
		sy = $sin(y); cy = $cos(y);
		m.r00 = to_q14(cp * cy);
		m.r10 = to_q14(cp * sy);
		m.r20 = to_q14(-sp);
		m.r21 = to_q14(sr * cp);
		m.r22 = to_q14(cr * cp);
		m.r02 = to_q14(cy * sp * cr + sy * sr);
		m.r12 = to_q14(sy * sp * cr - cy * sr);
		return m;
	endfunction

	function automatic real rand_angle(real span);
		return ($urandom_range(2000000) / 1000000.0 - 1.0) * span;
	endfunction

	function automatic matrix_t raw_matrix();
		logic [127:0] bits;
		matrix_t m;
		bits = {$urandom, $urandom, $urandom, $urandom};
		m = bits[$bits(matrix_t)-1:0];
		return m;
	endfunction

	// Random phase: mostly proper rotations, some close to gimbal lock, the
	// rest raw bit patterns that exercise saturation and full-scale inputs.
	task run_random(int count);
		int kind;
		real pole;
		for (int n = 0; n < count; n++) begin
			steady = (n >= count / 3 && n < count / 3 + 120);
			kind = $urandom_range(99);
			if (kind < 55) begin
				send_matrix(euler_matrix(rand_angle(3.14159), rand_angle(1.5707),
					rand_angle(3.14159)));
			end else if (kind < 75) begin
				pole = ($urandom_range(1) ? 1.5707963 : -1.5707963) + rand_angle(0.02);
				send_matrix(euler_matrix(rand_angle(3.14159), pole, rand_angle(3.14159)));
			end else begin
				send_matrix(raw_matrix());
			end
		end
		steady = 1'b0;
	endtask

	localparam logic signed [DW-1:0] ONE  = 16384;
	localparam logic signed [DW-1:0] MONE = -16384;
	localparam logic signed [DW-1:0] MAXV = 32767;
	localparam logic signed [DW-1:0] MINV = -32768;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset threshold of one.
		send_matrix('{ONE, 0, 0, 0, ONE, 0, 0});          // identity
		send_matrix('{0, 0, 0, 0, 0, 0, 0});              // all zero: locked, pitch 0
		send_matrix('{MONE, 0, 0, 0, MONE, 0, 0});        // negative x with zero y
		send_matrix('{0, MONE, 0, 0, MONE, 0, 0});
		send_matrix('{0, 0, MONE, 0, 0, ONE, 0});         // pitch +pi/2, locked
		send_matrix('{0, 0, ONE, 0, 0, MONE, ONE});       // pitch -pi/2, locked
		send_matrix('{0, 0, ONE, 0, 0, 0, MONE});
		send_matrix('{0, 0, 0, 0, 0, ONE, MONE});         // locked with pitch zero
		send_matrix('{MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV});
		send_matrix('{MINV, MINV, MAXV, MINV, MAXV, MINV, MAXV});
		send_matrix('{MINV, 0, 0, MINV, MINV, 0, 0});
		send_matrix('{0, MAXV, 0, 0, MAXV, MINV, MINV});
		send_matrix('{ONE, ONE, 0, ONE, MONE, 0, 0});
		send_matrix('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
			16'shAAAA, 16'sh5555});
		send_matrix('{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
			16'sh5555, 16'shAAAA});
		send_matrix(euler_matrix(0.5, 0.3, -2.0));
		send_matrix(euler_matrix(-3.0, -1.2, 3.1));
		run_random(N_RANDOM * 2 / 5);

		// Threshold zero never locks; the top value locks nearly everything.
		set_threshold(16'd0);
		send_matrix('{0, 0, 0, 0, 0, 0, 0});
		run_random(N_RANDOM / 5);
		set_threshold(16'hFFFF);
		send_matrix('{MAXV, 0, 0, MAXV, MAXV, ONE, ONE});
		run_random(N_RANDOM / 5);
		set_threshold(16'd400);
		run_random(N_RANDOM / 10);
		set_threshold(16'($urandom_range(1, 65534)));
		run_random(N_RANDOM / 10);

		mat_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("checked %0d angle triples, %0d in gimbal lock, over five lock thresholds",
			ledger.checked, ledger.lock_count);
		$display("inputs: rotations, near-pole rotations, raw extremes; random stalls");
		if (ledger.errors == 0 && ledger.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/rmrpy_pkg.sv
hdl/rmrpy_if.sv
hdl/rmrpy_cordic_cell.sv
hdl/rmrpy_sqrt_cell.sv
hdl/rmrpy_atan2.sv
hdl/rotation_matrix_to_roll_pitch_yaw.sv
hdl/rmrpy_checker.sv
tb/tb_rotation_matrix_to_roll_pitch_yaw.sv
